// ----- hw/rtl/lpht_pkg.sv -----
// shared types, codes and sizes of the linear-probe hash table
package lpht_pkg;

  // number of slots; a power of two, so the home slot is the low key bits
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 5;
  localparam int ENTRY_W = KEY_W + VALUE_W;

  // operation codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_DEAD  = 2'd2;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INS,
    WR_DEL
  } wr_kind_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       step;
    logic       finish;
    logic [1:0] status;
    wr_kind_t   wr;
    logic       publish;
  } lpht_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       match;
    logic       last;
    logic       have_free;
    logic       out_busy;
  } lpht_sts_t;

endpackage

// ----- hw/rtl/lpht_ctrl.sv -----
// probe sequencer of the linear-probe hash table
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lpht_sts_t sts,
  output lpht_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    ctl.wr      = WR_NONE;
    ctl.status  = ST_MISS;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.op == CMD_INSERT) begin
          priority if (sts.match) begin
            ctl.finish = 1'b1;
            ctl.status = ST_DUP;
          end else if (sts.empty) begin
            ctl.finish = 1'b1;
            ctl.status = ST_OK;
            ctl.wr     = WR_INS;
          end else if (sts.last) begin
            ctl.finish = 1'b1;
            ctl.status = sts.have_free ? ST_OK : ST_FULL;
            ctl.wr     = sts.have_free ? WR_INS : WR_NONE;
          end else begin
            ctl.step = 1'b1;
          end
        end else if (sts.op == CMD_LOOKUP || sts.op == CMD_DELETE) begin
          priority if (sts.match) begin
            ctl.finish = 1'b1;
            ctl.status = ST_OK;
            ctl.wr     = (sts.op == CMD_DELETE) ? WR_DEL : WR_NONE;
          end else if (sts.empty || sts.last) begin
            ctl.finish = 1'b1;
            ctl.status = ST_MISS;
          end else begin
            ctl.step = 1'b1;
          end
        end else begin
          // unused command answers not found
          ctl.finish = 1'b1;
          ctl.status = ST_MISS;
        end
        if (ctl.finish) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          ctl.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.step && ctl.finish))
    else $error("probe step and finish in the same cycle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> state_r == S_PROBE)
    else $error("accepted item did not start probing");

  a_finish_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> state_r == S_RESP)
    else $error("finished probe did not move to response");

endmodule

// ----- hw/rtl/lpht_dp.sv -----
// slot marks, entry memory, probe pointer and result registers
module lpht_dp import lpht_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VALUE_W-1:0]  in_value,
  input  lpht_ctl_t           ctl,
  output lpht_sts_t           sts,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [1:0]          out_status,
  output logic [VALUE_W-1:0]  out_found_value,
  output logic [SLOT_W-1:0]   out_slot_index
);

  logic [1:0]         mark_r [TABLE_SIZE];
  logic [ENTRY_W-1:0] slot_mem [TABLE_SIZE];
  logic [ENTRY_W-1:0] rd_r;

  logic [1:0]         cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   free_r;
  logic               free_valid_r;

  logic [1:0]         res_status_r;
  logic [VALUE_W-1:0] res_data_r;
  logic [SLOT_W-1:0]  res_slot_r;

  logic               out_tvalid_r;
  logic [1:0]         out_status_r;
  logic [VALUE_W-1:0] out_data_r;
  logic [SLOT_W-1:0]  out_slot_r;

  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   free_sel;
  logic [1:0]         cur_mark;
  logic               cur_used;

  // wraps round naturally since the table size is a power of two
  assign idx_inc  = idx_r + IDX_W'(1);
  assign rd_addr  = ctl.load ? in_key[IDX_W-1:0] : (ctl.step ? idx_inc : idx_r);
  assign cur_mark = mark_r[idx_r];
  assign cur_used = (cur_mark == MARK_USED);
  // first free slot seen so far, else the slot under the probe
  assign free_sel = free_valid_r ? free_r : idx_r;

  always_comb begin
    sts           = '0;
    sts.op        = cmd_r;
    sts.empty     = (cur_mark == MARK_EMPTY);
    sts.match     = cur_used && (rd_r[ENTRY_W-1:VALUE_W] == key_r);
    sts.last      = (cnt_r == IDX_W'(TABLE_SIZE - 1));
    sts.have_free = free_valid_r || !cur_used;
    sts.out_busy  = out_tvalid_r && !out_tready;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.finish && ctl.wr == WR_INS) begin
      slot_mem[free_sel] <= {key_r, value_r};
    end
    rd_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        mark_r[i] <= MARK_EMPTY;
      end
    end else if (ctl.finish) begin
      if (ctl.wr == WR_INS) begin
        mark_r[free_sel] <= MARK_USED;
      end else if (ctl.wr == WR_DEL) begin
        mark_r[idx_r] <= MARK_DEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_valid_r <= 1'b0;
    end else if (ctl.load) begin
      free_valid_r <= 1'b0;
    end else if (ctl.step && !cur_used) begin
      free_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
      idx_r   <= in_key[IDX_W-1:0];
      cnt_r   <= '0;
    end else if (ctl.step) begin
      idx_r <= idx_inc;
      cnt_r <= cnt_r + IDX_W'(1);
      if (!cur_used && !free_valid_r) begin
        free_r <= idx_r;
      end
    end
    if (ctl.finish) begin
      res_status_r <= ctl.status;
      res_data_r   <= '0;
      res_slot_r   <= '0;
      if (ctl.status == ST_OK) begin
        if (cmd_r == CMD_INSERT) begin
          res_slot_r <= SLOT_W'(free_sel);
        end else begin
          res_data_r <= rd_r[VALUE_W-1:0];
          res_slot_r <= SLOT_W'(idx_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.publish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_tvalid      = out_tvalid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_data_r;
  assign out_slot_index  = out_slot_r;

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> cnt_r != IDX_W'(TABLE_SIZE - 1))
    else $error("probe ran past the table size");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.finish && ctl.wr == WR_INS) |-> mark_r[free_sel] != MARK_USED)
    else $error("insert overwrote an occupied slot");

  a_delete_used: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.finish && ctl.wr == WR_DEL) |-> cur_used)
    else $error("delete hit a slot that is not occupied");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_status_r != ST_OK) |-> (out_data_r == '0 && out_slot_r == '0))
    else $error("failed operation carries data or slot");

endmodule

// ----- hw/rtl/linear_probe_hash_table_top.sv -----
// A key/data table with open addressing over TABLE_SIZE slots and linear probing
// from home slot key mod TABLE_SIZE. An operation accepts the item, probes one up to
// TABLE_SIZE slots, reading one slot a cycle from the entry memory (one read and one
// write port), and moves the result into the output register. A waiting result does
// not block the next item from being accepted and probed; that item's result is held
// until the output register is free. Slot marks sit in flip-flops cleared at reset,
// so no clearing pass is needed. in_tuser carries the command (0 insert, 1 lookup,
// 2 delete), out_tuser the status (0 ok, 1 duplicate, 2 not found, 3 full).
module linear_probe_hash_table_top import lpht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key [15:0], value [47:16]
  input  logic [1:0]  in_tuser,   // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_value [31:0], slot_index [36:32], zero [39:37]
  output logic [1:0]  out_tuser   // status [1:0]
);

  lpht_ctl_t          ctl;
  lpht_sts_t          sts;
  logic [VALUE_W-1:0] found_value;
  logic [SLOT_W-1:0]  slot_index;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lpht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_tuser),
    .in_key          (in_tdata[15:0]),
    .in_value        (in_tdata[47:16]),
    .ctl             (ctl),
    .sts             (sts),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_status      (out_tuser),
    .out_found_value (found_value),
    .out_slot_index  (slot_index)
  );

  assign out_tdata = {3'b000, slot_index, found_value};

endmodule
